// ----- hw/rtl/dqr_pkg.sv -----
// ----------------------------------------------------------------------------
// dqr_pkg: shared definitions for the double-ended queue with reverse
// Holds the queue geometry, the operation codes and the structs that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package dqr_pkg;

  // Number of slots in the ring; a power of two so that slot arithmetic wraps.
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;

  // Operation carried by each input word.
  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_REM_HEAD = 2'd2,
    OP_REVERSE  = 2'd3
  } opcode_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the input word and read the head slot
    logic exec;   // apply the operation and load the output register
  } dqr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dqr_status_t;

endpackage

// ----- hw/rtl/dqr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dqr_ctrl: operation sequencer
// Two-state controller: takes one word in IDLE, then applies it in EXEC as
// soon as the output register has room.
// ----------------------------------------------------------------------------
module dqr_ctrl
  import dqr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dqr_status_t status_i,
  output dqr_cmd_t    cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Next-state logic and command decode.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/dqr_dpath.sv -----
// ----------------------------------------------------------------------------
// dqr_dpath: ring buffer datapath
// Slot memory, front pointer, element count, orientation flag and the
// output register that holds one finished result.
// ----------------------------------------------------------------------------
module dqr_dpath
  import dqr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqr_cmd_t            cmd_i,
  output dqr_status_t         status_o,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [DATA_W-1:0]   value_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o,
  output logic [DATA_W-1:0]   removed_value_o,
  output logic [CNT_W-1:0]    occupancy_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rev_q, rev_d;

  opcode_e           op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] rd_data_q;

  logic              out_valid_q;
  logic              ok_q, ok_d;
  logic [DATA_W-1:0] removed_q, removed_d;
  logic [CNT_W-1:0]  occ_q;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              full, empty;
  logic [ADDR_W-1:0] cnt_lo, last_off;

  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign cnt_lo   = count_q[ADDR_W-1:0];
  assign last_off = cnt_lo - ADDR_W'(1);

  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Input word capture and registered read of the head slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= opcode_e'(opcode_i);
      val_q     <= value_in_i;
      rd_data_q <= mem_q[front_q];
    end
  end

  // Operation decode: pointer, count and flag updates plus the result.
  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    rev_d     = rev_q;
    ok_d      = 1'b0;
    removed_d = '0;
    wr_en     = 1'b0;
    wr_addr   = front_q;
    case (op_q)
      OP_INS_HEAD: begin
        if (!full) begin
          front_d = rev_q ? front_q + ADDR_W'(1) : front_q - ADDR_W'(1);
          wr_addr = front_d;
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      OP_INS_TAIL: begin
        if (!full) begin
          wr_addr = rev_q ? front_q - cnt_lo : front_q + cnt_lo;
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      OP_REM_HEAD: begin
        if (!empty) begin
          removed_d = rd_data_q;
          front_d   = rev_q ? front_q - ADDR_W'(1) : front_q + ADDR_W'(1);
          count_d   = count_q - CNT_W'(1);
          ok_d      = 1'b1;
        end
      end
      OP_REVERSE: begin
        // The old last element becomes the head.
        if (!empty) begin
          front_d = rev_q ? front_q - last_off : front_q + last_off;
        end
        rev_d = !rev_q;
        ok_d  = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Slot memory write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_addr] <= val_q;
    end
  end

  // Queue state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q      <= ok_d;
      removed_q <= removed_d;
      occ_q     <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign removed_value_o = removed_q;
  assign occupancy_o     = occ_q;

endmodule

// ----- hw/rtl/double_ended_queue_with_reverse.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse: bounded deque of 32-bit values
// Insert at head or tail, remove from head, reverse in one step.
// ----------------------------------------------------------------------------
// Each input word is one operation and yields exactly one output word. An
// operation runs in order: first the word is captured together with a
// registered read of the head slot, then the operation is applied to the
// ring memory and pointers and its result is loaded into the output
// register. The next word is accepted only once the previous one has been
// applied, since the registered read port of the slot memory needs the
// capture step to come first. A result left waiting at the output does not
// block the next word from being accepted; it only holds off its execution.
// The queue holds DEPTH words; a full queue rejects inserts and an empty
// queue rejects removes with ok low and a zero removed value.
module double_ended_queue_with_reverse
  import dqr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [31:0] value_in
  input  logic [OP_W-1:0]      s_axis_tuser_i,   // [1:0] opcode
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] removed_value, [36:32] occupancy
  output logic                 m_axis_tuser_o    // [0] ok
);

  dqr_cmd_t          cmd;
  dqr_status_t       status;
  logic [DATA_W-1:0] removed_value;
  logic [CNT_W-1:0]  occupancy;

  dqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dqr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (s_axis_tuser_i),
    .value_in_i      (s_axis_tdata_i[DATA_W-1:0]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .ok_o            (m_axis_tuser_o),
    .removed_value_o (removed_value),
    .occupancy_o     (occupancy)
  );

  // Pack the result word, padded with zeros to whole bytes.
  assign m_axis_tdata_o = {(M_TDATA_W - DATA_W - CNT_W)'(0), occupancy, removed_value};

endmodule
